// ===== sv/xcfr_pkg.sv =====
`default_nettype none

package xcfr_pkg;

  localparam int unsigned BYTE_W = 8;

  // Parser phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_CMD  = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  // Fixed bytes of the error reply
  localparam logic [BYTE_W-1:0] REPLY_LEN = 8'h02;
  localparam logic [BYTE_W-1:0] REPLY_PAD = 8'h00;

  // Beats of the error reply, in transmit order
  localparam int unsigned BEAT_W = 3;
  localparam logic [BEAT_W-1:0] BEAT_START = 3'd0;
  localparam logic [BEAT_W-1:0] BEAT_LEN   = 3'd1;
  localparam logic [BEAT_W-1:0] BEAT_CODE  = 3'd2;
  localparam logic [BEAT_W-1:0] BEAT_PAD   = 3'd3;
  localparam logic [BEAT_W-1:0] BEAT_SUM   = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ERROR_CODE   = 1'b1;

  // What one received byte leaves for the output stage
  typedef struct packed {
    logic              valid;
    logic              is_error;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] data_high;
    logic [BYTE_W-1:0] data_low;
  } xcfr_event_t;

endpackage

`default_nettype wire

// ===== sv/xcfr_parser.sv =====
`default_nettype none

module xcfr_parser
  import xcfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [BYTE_W-1:0] start_marker,
  output xcfr_event_t            evt
);

  logic [1:0]        phase, phase_next;
  logic [BYTE_W-1:0] remaining, remaining_next;
  logic [BYTE_W-1:0] held_command, held_command_next;
  logic [BYTE_W-1:0] held_high, held_high_next;
  logic [BYTE_W-1:0] held_low, held_low_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;

  // Decode one byte against the current phase
  always_comb begin
    phase_next        = phase;
    remaining_next    = remaining;
    held_command_next = held_command;
    held_high_next    = held_high;
    held_low_next     = held_low;
    running_xor_next  = running_xor;
    evt               = '0;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == start_marker) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        remaining_next   = rx_byte;
        running_xor_next = running_xor ^ rx_byte;
        phase_next       = PH_CMD;
      end
      PH_CMD: begin
        held_command_next = rx_byte;
        remaining_next    = remaining - 8'd1;
        running_xor_next  = running_xor ^ rx_byte;
        phase_next        = PH_BODY;
      end
      default: begin
        if (remaining == 8'd2) begin
          held_high_next   = rx_byte;
          remaining_next   = 8'd1;
          running_xor_next = running_xor ^ rx_byte;
        end else if (remaining == 8'd1) begin
          held_low_next    = rx_byte;
          remaining_next   = 8'd0;
          running_xor_next = running_xor ^ rx_byte;
        end else begin
          // Checksum byte, or a count too large: either way restart
          evt.valid = 1'b1;
          if (remaining != 8'd0 || rx_byte != running_xor) begin
            evt.is_error = 1'b1;
          end else begin
            evt.command   = held_command;
            evt.data_high = held_high;
            evt.data_low  = held_low;
          end
          phase_next        = PH_HUNT;
          remaining_next    = '0;
          held_command_next = '0;
          held_high_next    = '0;
          held_low_next     = '0;
          running_xor_next  = '0;
        end
      end
    endcase
    if (!take) begin
      evt.valid = 1'b0;
    end
  end

  // Advance parser state on each taken byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      remaining    <= '0;
      held_command <= '0;
      held_high    <= '0;
      held_low     <= '0;
      running_xor  <= '0;
    end else if (take) begin
      phase        <= phase_next;
      remaining    <= remaining_next;
      held_command <= held_command_next;
      held_high    <= held_high_next;
      held_low     <= held_low_next;
      running_xor  <= running_xor_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/xor_checked_frame_receiver_core.sv =====
`default_nettype none

// Frame receiver with XOR checksum. Received bytes enter on s_axis one per cycle
// unless held off; the parser hunts for start_marker, then takes a length byte,
// a command byte, up to two data bytes (high first) and a checksum equal to the
// XOR of length, command and data. A good frame yields one item on m_axis (tuser 0)
// carrying command and data; a bad checksum or a length byte of 0 or above 3 yields
// five items (tuser 1) carrying the error reply bytes start_marker, 2, error_code,
// 0, checksum, with tlast on the fifth. Input is held off only while a result still
// waits in the single output register, so an error reply blocks input until its
// fifth beat is taken. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
module xor_checked_frame_receiver_core
  import xcfr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,  // rx_byte[7:0]
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // frame_command[7:0], frame_data_high[15:8], frame_data_low[23:16], tx_byte[31:24]
  output      logic [31:0]            m_axis_tdata,
  output      logic                   m_axis_tuser,  // kind
  output      logic                   m_axis_tlast,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_data
);

  logic [BYTE_W-1:0] start_marker;
  logic [BYTE_W-1:0] error_code;
  xcfr_event_t       evt;
  logic              take;
  logic              last_beat;
  logic              drain;

  logic              kind;
  logic [BEAT_W-1:0] beat;
  logic [BYTE_W-1:0] out_command;
  logic [BYTE_W-1:0] out_high;
  logic [BYTE_W-1:0] out_low;
  logic [BYTE_W-1:0] tx_byte;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= '0;
      error_code   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_MARKER: start_marker <= cfg_data;
        REG_ERROR_CODE:   error_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a byte when the output register is free or empties this cycle
  assign last_beat     = !kind || (beat == BEAT_SUM);
  assign drain         = m_axis_tvalid && m_axis_tready && last_beat;
  assign s_axis_tready = !m_axis_tvalid || drain;
  assign take          = s_axis_tvalid && s_axis_tready;

  xcfr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .rx_byte      (s_axis_tdata),
    .start_marker (start_marker),
    .evt          (evt)
  );

  // Output register: load an event, step through the reply beats
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      kind          <= 1'b0;
      beat          <= BEAT_START;
    end else if (evt.valid) begin
      m_axis_tvalid <= 1'b1;
      kind          <= evt.is_error;
      beat          <= BEAT_START;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (last_beat) begin
        m_axis_tvalid <= 1'b0;
      end else begin
        beat <= beat + 3'd1;
      end
    end
  end

  // Hold frame payload
  always_ff @(posedge clk) begin
    if (evt.valid) begin
      out_command <= evt.command;
      out_high    <= evt.data_high;
      out_low     <= evt.data_low;
    end
  end

  // Select the reply byte for the current beat
  always_comb begin
    tx_byte = '0;
    if (kind) begin
      case (beat)
        BEAT_START: tx_byte = start_marker;
        BEAT_LEN:   tx_byte = REPLY_LEN;
        BEAT_CODE:  tx_byte = error_code;
        BEAT_PAD:   tx_byte = REPLY_PAD;
        BEAT_SUM:   tx_byte = REPLY_LEN ^ error_code ^ REPLY_PAD;
        default:    tx_byte = '0;
      endcase
    end
  end

  assign m_axis_tdata = {tx_byte, out_low, out_high, out_command};
  assign m_axis_tuser = kind;
  assign m_axis_tlast = last_beat;

endmodule

`default_nettype wire
